// ===== src/byte_stack_with_front_drain_unit_macros.svh =====
`ifndef BYTE_STACK_WITH_FRONT_DRAIN_UNIT_MACROS_SVH
`define BYTE_STACK_WITH_FRONT_DRAIN_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BSWFD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define BSWFD_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/bswfd_pkg.sv =====
package bswfd_pkg;

  localparam int DATA_W = 8;
  localparam int FILL_W = 9;
  localparam int CNT_W  = 7;

  localparam int DEPTH_DEF    = 256;
  localparam int MAX_TAKE_DEF = 64;
  localparam logic [FILL_W-1:0] CAP_RESET = 9'd256;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = 1;
  localparam int CQ_CNT_W = 2;

  // result queue on the output side
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_TAKE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FAULT    = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_TAKE = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] data_in;
    logic [CNT_W-1:0]  take_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic              last;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              over_max;
    logic              zero;
  } cmd_t;

endpackage

// ===== src/bswfd_front.sv =====
module bswfd_front #(
  parameter int MAX_TAKE = bswfd_pkg::MAX_TAKE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bswfd_pkg::in_item_t in_item_i,
  input  logic                push_i,
  output logic                full_o,
  output bswfd_pkg::cmd_t     cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_take_i
);

  localparam int PW = bswfd_pkg::CQ_PTR_W;
  localparam int CW = bswfd_pkg::CQ_CNT_W;

  bswfd_pkg::cmd_t q_mem [bswfd_pkg::CQ_DEPTH];
  bswfd_pkg::cmd_t dec;
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push_ok, take_ok;

  // classify the incoming item
  always_comb begin
    dec.op       = bswfd_pkg::op_e'(in_item_i.op);
    dec.data     = in_item_i.data_in;
    dec.count    = in_item_i.take_count;
    dec.over_max = 32'(in_item_i.take_count) > MAX_TAKE;
    dec.zero     = in_item_i.take_count == '0;
  end

  assign full_o      = cnt_q == CW'(bswfd_pkg::CQ_DEPTH);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push_ok     = push_i && !full_o;
  assign take_ok     = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = take_ok ? rd_ptr_q + 1'b1 : rd_ptr_q;
    unique case ({push_ok, take_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

endmodule

// ===== src/bswfd_back.sv =====
`include "byte_stack_with_front_drain_unit_macros.svh"

module bswfd_back #(
  parameter int DEPTH = bswfd_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bswfd_pkg::FILL_W-1:0] cfg_wdata_i,
  input  bswfd_pkg::cmd_t             cmd_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_take_o,
  output bswfd_pkg::out_item_t        out_item_o,
  output logic                        empty_o,
  input  logic                        pop_i
);

  localparam int FW  = bswfd_pkg::FILL_W;
  localparam int DW  = bswfd_pkg::DATA_W;
  localparam int NW  = bswfd_pkg::CNT_W;
  localparam int AW  = $clog2(DEPTH);
  localparam int SW  = ((AW > FW) ? AW : FW) + 1;
  localparam int OPW = bswfd_pkg::OUT_PTR_W;
  localparam int OCW = bswfd_pkg::OUT_CNT_W;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  logic [FW-1:0] cap_q;
  logic [FW-1:0] fill_q, fill_d, eff_cap;
  logic [AW-1:0] bot_q, bot_d, bot_inc;
  logic [NW-1:0] remain_q, remain_d;
  bswfd_pkg::back_state_e state_q, state_d;

  logic [SW-1:0] top_sum, pop_sum;
  logic [AW-1:0] wr_addr, pop_addr, rd_addr;
  logic          we, re, space;

  logic          a_valid, a_rd, a_last;
  logic [1:0]    a_status;

  logic          b_valid_q, b_rd_q, b_last_q;
  logic [1:0]    b_status_q;
  logic [FW-1:0] b_fill_q;

  bswfd_pkg::out_item_t fifo_q [bswfd_pkg::OUT_DEPTH];
  bswfd_pkg::out_item_t b_item;
  logic [OPW-1:0] o_wr_q, o_rd_q;
  logic [OCW-1:0] o_cnt_q;
  logic           o_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bswfd_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign eff_cap = (32'(cap_q) > DEPTH) ? FW'(DEPTH) : cap_q;

  // circular addresses: top slot and newest byte
  assign top_sum  = SW'(bot_q) + SW'(fill_q);
  assign pop_sum  = top_sum - SW'(1);
  assign wr_addr  = (top_sum >= SW'(DEPTH)) ? AW'(top_sum - SW'(DEPTH)) : AW'(top_sum);
  assign pop_addr = (pop_sum >= SW'(DEPTH)) ? AW'(pop_sum - SW'(DEPTH)) : AW'(pop_sum);
  assign bot_inc  = (bot_q == AW'(DEPTH - 1)) ? '0 : bot_q + 1'b1;

  // room for one more result, counting the one in flight
  assign space = (o_cnt_q + OCW'(b_valid_q)) < OCW'(bswfd_pkg::OUT_DEPTH);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    bot_d      = bot_q;
    remain_d   = remain_q;
    cmd_take_o = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    rd_addr    = bot_q;
    a_valid    = 1'b0;
    a_rd       = 1'b0;
    a_last     = 1'b1;
    a_status   = bswfd_pkg::ST_OK;
    unique case (state_q)
      bswfd_pkg::BK_IDLE: begin
        if (cmd_valid_i && space) begin
          cmd_take_o = 1'b1;
          a_valid    = 1'b1;
          unique case (cmd_i.op)
            bswfd_pkg::OP_PUSH: begin
              if (fill_q >= eff_cap) begin
                a_status = bswfd_pkg::ST_OVERFLOW;
              end else begin
                we     = 1'b1;
                fill_d = fill_q + 1'b1;
              end
            end
            bswfd_pkg::OP_POP: begin
              if (fill_q == '0) begin
                a_status = bswfd_pkg::ST_EMPTY;
              end else begin
                re      = 1'b1;
                rd_addr = pop_addr;
                fill_d  = fill_q - 1'b1;
                a_rd    = 1'b1;
              end
            end
            bswfd_pkg::OP_TAKE: begin
              if (cmd_i.over_max || FW'(cmd_i.count) > fill_q) begin
                a_status = bswfd_pkg::ST_FAULT;
              end else if (!cmd_i.zero) begin
                re       = 1'b1;
                bot_d    = bot_inc;
                fill_d   = fill_q - 1'b1;
                a_rd     = 1'b1;
                remain_d = cmd_i.count - 1'b1;
                if (cmd_i.count != NW'(1)) begin
                  a_last  = 1'b0;
                  state_d = bswfd_pkg::BK_TAKE;
                end
              end
            end
            bswfd_pkg::OP_CLEAR: begin
              bot_d  = '0;
              fill_d = '0;
            end
            default: ;
          endcase
        end
      end
      bswfd_pkg::BK_TAKE: begin
        // one byte of the run per cycle from the bottom, while the result queue has room
        if (space) begin
          a_valid  = 1'b1;
          re       = 1'b1;
          bot_d    = bot_inc;
          fill_d   = fill_q - 1'b1;
          a_rd     = 1'b1;
          remain_d = remain_q - 1'b1;
          a_last   = remain_q == NW'(1);
          if (remain_q == NW'(1)) begin
            state_d = bswfd_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = bswfd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bswfd_pkg::BK_IDLE;
      fill_q    <= '0;
      bot_q     <= '0;
      remain_q  <= '0;
      b_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      bot_q     <= bot_d;
      remain_q  <= remain_d;
      b_valid_q <= a_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    b_rd_q     <= a_rd;
    b_last_q   <= a_last;
    b_status_q <= a_status;
    b_fill_q   <= fill_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    b_item.status     = b_status_q;
    b_item.data_out   = b_rd_q ? rdata_q : '0;
    b_item.data_valid = b_rd_q;
    b_item.last       = b_last_q;
    b_item.fill_level = b_fill_q;
  end

  assign empty_o    = o_cnt_q == '0;
  assign out_item_o = fifo_q[o_rd_q];
  assign o_pop      = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_wr_q  <= '0;
      o_rd_q  <= '0;
      o_cnt_q <= '0;
    end else begin
      if (b_valid_q) begin
        o_wr_q <= o_wr_q + 1'b1;
      end
      if (o_pop) begin
        o_rd_q <= o_rd_q + 1'b1;
      end
      unique case ({b_valid_q, o_pop})
        2'b10:   o_cnt_q <= o_cnt_q + 1'b1;
        2'b01:   o_cnt_q <= o_cnt_q - 1'b1;
        default: o_cnt_q <= o_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      fifo_q[o_wr_q] <= b_item;
    end
  end

  `BSWFD_ASSERT(a_fill_bound, clk_i, rst_ni, 32'(fill_q) <= DEPTH, "fill count above depth")
  `BSWFD_ASSERT(a_out_room, clk_i, rst_ni, b_valid_q |-> (o_cnt_q < OCW'(bswfd_pkg::OUT_DEPTH)), "result queue overrun")
  `BSWFD_NEVER(a_take_remain, clk_i, rst_ni, (state_q == bswfd_pkg::BK_TAKE) && (remain_q == '0), "take run with nothing left")
  `BSWFD_ASSERT(a_take_no_cmd, clk_i, rst_ni, (state_q == bswfd_pkg::BK_TAKE) |-> !cmd_take_o, "command taken during take run")

endmodule

// ===== src/byte_stack_with_front_drain_unit.sv =====
// Byte buffer with push/pop at the top and a bulk take of the oldest bytes at
// the bottom. Items enter through a two-entry command queue; the back end does
// at most one memory access per cycle. Push, pop, clear, a fault and a take of
// zero each give one result, a take of n bytes gives n. A result is registered
// in the b stage before it enters the output queue, and the single read port
// of the byte store sets the one-byte-per-cycle rate while the output queue
// has room. Every result carries status and the fill level after it.
module byte_stack_with_front_drain_unit #(
  parameter int DEPTH    = bswfd_pkg::DEPTH_DEF,
  parameter int MAX_TAKE = bswfd_pkg::MAX_TAKE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bswfd_pkg::FILL_W-1:0] cfg_wdata_i,
  input  bswfd_pkg::in_item_t          in_item_i,
  input  logic                         push,
  output logic                         full,
  output bswfd_pkg::out_item_t         out_item_o,
  output logic                         empty,
  input  logic                         pop
);

  bswfd_pkg::cmd_t cmd;
  logic            cmd_valid, cmd_take;

  bswfd_front #(
    .MAX_TAKE(MAX_TAKE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .push_i     (push),
    .full_o     (full),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_take_i (cmd_take)
  );

  bswfd_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_take_o (cmd_take),
    .out_item_o (out_item_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT       = 4_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 6;

  typedef struct {
    bswfd_pkg::in_item_t  item;
    bit                   typed;
    bswfd_pkg::out_item_t want;
  } dir_row_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [bswfd_pkg::FILL_W-1:0] cfg_wdata_i = '0;
  bswfd_pkg::in_item_t          in_item_i   = '0;
  logic                         push        = 1'b0;
  logic                         full;
  bswfd_pkg::out_item_t         out_item_o;
  logic                         empty;
  logic                         pop         = 1'b0;

  // shadow copy of the buffer
  logic [bswfd_pkg::DATA_W-1:0] shadow_bytes [bswfd_pkg::DEPTH_DEF];
  logic [7:0]                   shadow_bottom = '0;
  logic [bswfd_pkg::FILL_W-1:0] shadow_fill   = '0;
  logic [bswfd_pkg::FILL_W-1:0] shadow_cap    = bswfd_pkg::CAP_RESET;

  bswfd_pkg::out_item_t pending_results [$];
  bswfd_pkg::out_item_t op_results [$];
  dir_row_t             dir_rows [$];

  int unsigned cycles      = 0;
  int unsigned errors      = 0;
  int unsigned n_items     = 0;
  int unsigned n_results   = 0;
  int unsigned n_drained   = 0;
  int unsigned peak_fill   = 0;
  int unsigned full_stalls = 0;
  int unsigned hold_left   = 0;
  int unsigned pop_gap     = 0;
  bit          hold_req    = 1'b0;

  byte_stack_with_front_drain_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_item_i  (in_item_i),
    .push       (push),
    .full       (full),
    .out_item_o (out_item_o),
    .empty      (empty),
    .pop        (pop)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // mostly back to back, sometimes a few cycles, rarely a long gap
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_result(bswfd_pkg::status_e st,
                                     logic [bswfd_pkg::DATA_W-1:0] d, logic v, logic l);
    bswfd_pkg::out_item_t r;
    r.status     = st;
    r.data_out   = d;
    r.data_valid = v;
    r.last       = l;
    r.fill_level = shadow_fill;
    op_results.push_back(r);
  endfunction

  function automatic void apply_byte_op(input bswfd_pkg::in_item_t it);
    logic [bswfd_pkg::FILL_W-1:0] room;
    logic [7:0]                   idx;
    int                           n;
    op_results.delete();
    room = (shadow_cap > bswfd_pkg::FILL_W'(bswfd_pkg::DEPTH_DEF)) ?
           bswfd_pkg::FILL_W'(bswfd_pkg::DEPTH_DEF) : shadow_cap;
    n = int'(it.take_count);
    case (bswfd_pkg::op_e'(it.op))
      bswfd_pkg::OP_PUSH: begin
        if (shadow_fill >= room) begin
          add_result(bswfd_pkg::ST_OVERFLOW, '0, 1'b0, 1'b1);
        end else begin
          idx = shadow_bottom + shadow_fill[7:0];
          shadow_bytes[idx] = it.data_in;
          shadow_fill++;
          add_result(bswfd_pkg::ST_OK, '0, 1'b0, 1'b1);
        end
      end
      bswfd_pkg::OP_POP: begin
        if (shadow_fill == 0) begin
          add_result(bswfd_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          shadow_fill--;
          idx = shadow_bottom + shadow_fill[7:0];
          add_result(bswfd_pkg::ST_OK, shadow_bytes[idx], 1'b1, 1'b1);
        end
      end
      bswfd_pkg::OP_TAKE: begin
        if (n > int'(shadow_fill) || n > bswfd_pkg::MAX_TAKE_DEF) begin
          add_result(bswfd_pkg::ST_FAULT, '0, 1'b0, 1'b1);
        end else if (n == 0) begin
          add_result(bswfd_pkg::ST_OK, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            idx = shadow_bottom;
            shadow_bottom++;
            shadow_fill--;
            add_result(bswfd_pkg::ST_OK, shadow_bytes[idx], 1'b1, i == n - 1);
          end
          n_drained += n;
        end
      end
      default: begin
        shadow_bottom = '0;
        shadow_fill   = '0;
        add_result(bswfd_pkg::ST_OK, '0, 1'b0, 1'b1);
      end
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
  endfunction

  function automatic void add_row(bswfd_pkg::op_e op, logic [7:0] d, logic [6:0] cnt,
                                  bit typed, bswfd_pkg::status_e st,
                                  logic [bswfd_pkg::FILL_W-1:0] fill);
    dir_row_t row;
    row.item.op          = op;
    row.item.data_in     = d;
    row.item.take_count  = cnt;
    row.typed            = typed;
    row.want.status      = st;
    row.want.data_out    = '0;
    row.want.data_valid  = 1'b0;
    row.want.last        = 1'b1;
    row.want.fill_level  = fill;
    dir_rows.push_back(row);
  endfunction

  function automatic bswfd_pkg::in_item_t rand_item();
    bswfd_pkg::in_item_t it;
    int unsigned         r;
    int unsigned         k;
    int unsigned         top;
    it.data_in    = bswfd_pkg::DATA_W'($urandom);
    it.take_count = bswfd_pkg::CNT_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 50) begin
      it.op = bswfd_pkg::OP_PUSH;
    end else if (r < 65) begin
      it.op = bswfd_pkg::OP_POP;
    end else if (r < 95) begin
      it.op = bswfd_pkg::OP_TAKE;
      k = $urandom_range(0, 9);
      top = (shadow_fill > 64) ? 64 : shadow_fill;
      if (k < 6) it.take_count = bswfd_pkg::CNT_W'($urandom_range(0, top));
      else if (k < 8) it.take_count = bswfd_pkg::CNT_W'($urandom_range(0, 64));
      else it.take_count = bswfd_pkg::CNT_W'($urandom_range(65, 127));
    end else begin
      it.op = bswfd_pkg::OP_CLEAR;
    end
    return it;
  endfunction

  task automatic send_item(input bswfd_pkg::in_item_t it, input bit typed,
                           input bswfd_pkg::out_item_t want);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full !== 1'b0);
    apply_byte_op(it);
    if (typed) pending_results.push_back(want);
    else foreach (op_results[k]) pending_results.push_back(op_results[k]);
    n_items++;
  endtask

  task automatic drain_all();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [bswfd_pkg::FILL_W-1:0] v);
    drain_all();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_cap = v;
  endtask

  // result side: drive pop at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // result side: check each transfer at the rising edge
  always @(posedge clk_i) begin
    bswfd_pkg::out_item_t e;
    if (rst_ni) begin
      if (hold_left > 0 && full === 1'b1) full_stalls++;
      if (pop === 1'b1 && empty === 1'b0) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d data_out %0h fill_level %0d",
                 out_item_o.status, out_item_o.data_out, out_item_o.fill_level);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_item_o.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_item_o.status);
            errors++;
          end
          if (out_item_o.data_out !== e.data_out) begin
            $error("data_out: expected %0h, got %0h", e.data_out, out_item_o.data_out);
            errors++;
          end
          if (out_item_o.data_valid !== e.data_valid) begin
            $error("data_valid: expected %0d, got %0d", e.data_valid, out_item_o.data_valid);
            errors++;
          end
          if (out_item_o.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_item_o.last);
            errors++;
          end
          if (out_item_o.fill_level !== e.fill_level) begin
            $error("fill_level: expected %0d, got %0d", e.fill_level, out_item_o.fill_level);
            errors++;
          end
        end
        pop_gap = pick_gap();
      end
    end
  end

  initial begin
    logic [bswfd_pkg::FILL_W-1:0] caps [7];
    bswfd_pkg::in_item_t          it;
    bswfd_pkg::out_item_t         none;
    caps = '{9'd5, 9'd2, 9'd0, 9'd1, 9'd3, 9'd40, 9'd256};
    none = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset capacity
    add_row(bswfd_pkg::OP_POP,   8'h00, 7'd0,   1, bswfd_pkg::ST_EMPTY, 9'd0);
    add_row(bswfd_pkg::OP_TAKE,  8'h00, 7'd0,   1, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_TAKE,  8'h00, 7'd1,   1, bswfd_pkg::ST_FAULT, 9'd0);
    add_row(bswfd_pkg::OP_PUSH,  8'h00, 7'd0,   1, bswfd_pkg::ST_OK,    9'd1);
    add_row(bswfd_pkg::OP_PUSH,  8'hFF, 7'd0,   1, bswfd_pkg::ST_OK,    9'd2);
    add_row(bswfd_pkg::OP_PUSH,  8'hA5, 7'd0,   0, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_PUSH,  8'h5A, 7'd0,   0, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_POP,   8'h00, 7'd0,   0, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_TAKE,  8'h00, 7'd127, 1, bswfd_pkg::ST_FAULT, 9'd3);
    add_row(bswfd_pkg::OP_TAKE,  8'h00, 7'd65,  1, bswfd_pkg::ST_FAULT, 9'd3);
    add_row(bswfd_pkg::OP_TAKE,  8'h00, 7'd4,   1, bswfd_pkg::ST_FAULT, 9'd3);
    add_row(bswfd_pkg::OP_TAKE,  8'h00, 7'd2,   0, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_PUSH,  8'h81, 7'd0,   0, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_POP,   8'h00, 7'd0,   0, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_POP,   8'h00, 7'd0,   0, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_POP,   8'h00, 7'd0,   1, bswfd_pkg::ST_EMPTY, 9'd0);
    add_row(bswfd_pkg::OP_PUSH,  8'h7E, 7'd127, 0, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_PUSH,  8'h33, 7'd0,   0, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_CLEAR, 8'hFF, 7'd127, 1, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_TAKE,  8'h00, 7'd0,   1, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_PUSH,  8'hC3, 7'd0,   0, bswfd_pkg::ST_OK,    9'd0);
    add_row(bswfd_pkg::OP_TAKE,  8'h00, 7'd1,   0, bswfd_pkg::ST_OK,    9'd0);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // capacity above depth: fill the whole store while the receiver holds off
    set_capacity(9'd511);
    @(posedge clk_i);
    hold_req = 1'b1;
    while (shadow_fill < bswfd_pkg::DEPTH_DEF) begin
      it = rand_item();
      it.op = ($urandom_range(0, 49) == 0) ? bswfd_pkg::OP_POP : bswfd_pkg::OP_PUSH;
      send_item(it, 0, none);
    end
    repeat (3) begin
      it = rand_item();
      it.op = bswfd_pkg::OP_PUSH;
      send_item(it, 0, none);
    end
    it = rand_item();
    it.op = bswfd_pkg::OP_TAKE;
    it.take_count = 7'd65;
    send_item(it, 0, none);
    repeat (3) begin
      it.take_count = 7'd64;
      send_item(it, 0, none);
    end

    // random phases; the first one lowers capacity below the fill
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      repeat (PHASE_ITEMS) send_item(rand_item(), 0, none);
    end

    drain_all();
    repeat (30) @(posedge clk_i);

    $display("%0d items sent, %0d results checked, %0d bytes drained by take, peak fill %0d",
             n_items, n_results, n_drained, peak_fill);
    $display("capacity walked 256 511 5 2 0 1 3 40 256, input held by full on %0d cycles",
             full_stalls);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
